@@ src/p1305_pkg.sv @@
// shared types and constants for the poly1305 mac
package p1305_pkg;
	localparam int unsigned BLK_BYTES = 16;
	localparam int unsigned CNT_W = 4;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_R_LOW  = 2'd0,
		REG_R_HIGH = 2'd1,
		REG_S_LOW  = 2'd2,
		REG_S_HIGH = 2'd3
	} reg_idx_t;

	// work handed from front to back: one 128-bit block plus flags
	typedef struct packed {
		logic [127:0] blk;
		logic         absorb;
		logic         hibit;
		logic         fin;
	} job_t;

	// multiplier sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_RED,
		ST_FIN
	} bk_state_t;
endpackage

@@ src/p1305_front.sv @@
// front end: collects bytes into blocks, pads on last, issues jobs
module p1305_front import p1305_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   data_byte,
	input  logic         has_byte,
	input  logic         last,
	output logic         job_valid,
	input  logic         job_ready,
	output job_t         job
);
	logic [7:0]       buf_q [BLK_BYTES];
	logic [CNT_W-1:0] cnt_q;
	logic [127:0]     cur_blk;
	logic [127:0]     pad_blk;
	logic             full_now;
	logic [CNT_W:0]   n_after;

	assign in_ready = job_ready;

	// current buffer plus the incoming byte
	always_comb begin
		for (int i = 0; i < BLK_BYTES; i++) begin
			cur_blk[i*8 +: 8] = buf_q[i];
			if (has_byte && cnt_q == CNT_W'(i))
				cur_blk[i*8 +: 8] = data_byte;
		end
	end

	assign n_after  = {1'b0, cnt_q} + (CNT_W+1)'(has_byte);
	assign full_now = n_after[CNT_W];

	// padded partial block: 0x01 after the data, zero fill
	always_comb begin
		for (int i = 0; i < BLK_BYTES; i++) begin
			if (CNT_W'(i) < n_after[CNT_W-1:0])
				pad_blk[i*8 +: 8] = cur_blk[i*8 +: 8];
			else if (CNT_W'(i) == n_after[CNT_W-1:0])
				pad_blk[i*8 +: 8] = 8'h01;
			else
				pad_blk[i*8 +: 8] = 8'h00;
		end
	end

	// job selection
	always_comb begin
		job_valid  = 1'b0;
		job.blk    = cur_blk;
		job.absorb = 1'b0;
		job.hibit  = 1'b0;
		job.fin    = 1'b0;
		if (in_valid) begin
			if (full_now) begin
				job_valid  = 1'b1;
				job.absorb = 1'b1;
				job.hibit  = 1'b1;
				job.fin    = last;
			end else if (last) begin
				job_valid  = 1'b1;
				job.blk    = pad_blk;
				job.absorb = (n_after[CNT_W-1:0] != '0);
				job.fin    = 1'b1;
			end
		end
	end

	// byte buffer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready && has_byte)
			buf_q[cnt_q] <= data_byte;
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_valid && in_ready) begin
			if (last || full_now)
				cnt_q <= '0;
			else
				cnt_q <= n_after[CNT_W-1:0];
		end
	end
endmodule

@@ src/p1305_fifo.sv @@
// short job queue between front and back
module p1305_fifo import p1305_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_job,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_job
);
	job_t       mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       wr_en, rd_en;

	assign wr_ready = (cnt_q != 3'd4);
	assign rd_valid = (cnt_q != 3'd0);
	assign rd_job   = mem_q[rp_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	// storage
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wp_q] <= wr_job;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wp_q <= wp_q + 2'd1;
			if (rd_en)
				rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr_en) - 3'(rd_en);
		end
	end
endmodule

@@ src/p1305_back.sv @@
// back end: block multiply by r one column at a time, reduce, finalize tag
module p1305_back import p1305_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  job_t          job,
	input  logic [127:0]  r_key,
	input  logic [127:0]  s_key,
	output logic          tag_valid,
	input  logic          tag_ready,
	output logic [127:0]  tag
);
	bk_state_t    st_q, st_d;
	logic [130:0] h_q;
	logic [130:0] a_q;
	logic [2:0]   k_q;
	logic [31:0]  m_q [5];
	logic [31:0]  carry_q;
	logic [127:0] r_c;
	logic [31:0]  r0, r1, r2, r3, s1, s2, s3;
	logic         fin_q;
	logic         out_v_q;
	logic         fin_fire;
	logic [127:0] out_q;
	logic [31:0]  hw [5];
	logic [31:0]  cf [5];
	logic [63:0]  col;
	logic [130:0] sum_in;
	logic [31:0]  fold_c;
	logic [130:0] red;
	logic [130:0] g;
	logic [127:0] hsel;

	assign r_c = r_key & 128'h0ffffffc0ffffffc0ffffffc0fffffff;

	// clamped r limbs and the 5/4 multiples used for wrapped columns
	assign r0 = r_c[31:0];
	assign r1 = r_c[63:32];
	assign r2 = r_c[95:64];
	assign r3 = r_c[127:96];
	assign s1 = r1 + (r1 >> 2);
	assign s2 = r2 + (r2 >> 2);
	assign s3 = r3 + (r3 >> 2);

	// accumulator limbs of the current job
	assign hw[0] = a_q[31:0];
	assign hw[1] = a_q[63:32];
	assign hw[2] = a_q[95:64];
	assign hw[3] = a_q[127:96];
	assign hw[4] = {29'd0, a_q[130:128]};

	// limb coefficients for the column being built
	always_comb begin
		case (k_q)
			3'd0: begin
				cf[0] = r0;
				cf[1] = s3;
				cf[2] = s2;
				cf[3] = s1;
				cf[4] = '0;
			end
			3'd1: begin
				cf[0] = r1;
				cf[1] = r0;
				cf[2] = s3;
				cf[3] = s2;
				cf[4] = s1;
			end
			3'd2: begin
				cf[0] = r2;
				cf[1] = r1;
				cf[2] = r0;
				cf[3] = s3;
				cf[4] = s2;
			end
			3'd3: begin
				cf[0] = r3;
				cf[1] = r2;
				cf[2] = r1;
				cf[3] = r0;
				cf[4] = s3;
			end
			default: begin
				cf[0] = '0;
				cf[1] = '0;
				cf[2] = '0;
				cf[3] = '0;
				cf[4] = r0;
			end
		endcase
	end

	// one product column per cycle, 32x32 multipliers, plus the running carry
	always_comb begin
		col = {32'd0, carry_q};
		for (int j = 0; j < 5; j++)
			col = col + {32'd0, hw[j]} * {32'd0, cf[j]};
	end

	// add block into accumulator
	assign sum_in = h_q + {3'b0, job.blk} + {2'b0, job.hibit, 128'd0};

	// partial reduction: fold bits 130 and up times 5
	assign fold_c = (m_q[4] >> 2) + (m_q[4] & ~32'd3);
	assign red    = {1'b0, m_q[4][1:0], m_q[3], m_q[2], m_q[1], m_q[0]} + {99'd0, fold_c};

	// final reduction and add s
	assign g    = h_q + 131'd5;
	assign hsel = g[130] ? g[127:0] : h_q[127:0];

	assign fin_fire  = (st_q == ST_FIN) && (!out_v_q || tag_ready);
	assign job_ready = (st_q == ST_IDLE) && !(out_v_q && !tag_ready);
	assign tag_valid = out_v_q;
	assign tag       = out_q;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (job_valid && job_ready)
				st_d = job.absorb ? ST_MUL : ST_FIN;
			ST_MUL:  if (k_q == 3'd4) st_d = ST_RED;
			ST_RED:  st_d = fin_q ? ST_FIN : ST_IDLE;
			ST_FIN:  if (!out_v_q || tag_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			h_q     <= '0;
			a_q     <= '0;
			k_q     <= '0;
			carry_q <= '0;
			for (int i = 0; i < 5; i++) m_q[i] <= '0;
			fin_q   <= 1'b0;
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else begin
			st_q    <= st_d;
			out_v_q <= fin_fire || (out_v_q && !tag_ready);
			unique case (st_q)
				ST_IDLE: if (job_valid && job_ready) begin
					a_q     <= sum_in;
					fin_q   <= job.fin;
					k_q     <= '0;
					carry_q <= '0;
				end
				ST_MUL: begin
					m_q[k_q] <= col[31:0];
					carry_q  <= col[63:32];
					k_q      <= k_q + 3'd1;
				end
				ST_RED: h_q <= red;
				ST_FIN: if (fin_fire) begin
					out_q <= hsel + s_key;
					h_q   <= '0;
				end
				default: ;
			endcase
		end
	end
endmodule

@@ src/poly1305_mac.sv @@
// poly1305 mac top level: key registers, front end, job queue, back end
// the last block goes through 5 multiply steps, a reduce step and a finalize step before the tag
// one byte per cycle while the job queue has room; the back end takes a new block only when done with the last
// a finish-only item goes straight to finalize; a short last block is multiplied, reduced, then finalized
// reset clears accumulator, fill count, queue and key registers
module poly1305_mac import p1305_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // data_byte[7:0]
	input  logic         s_tuser,  // has_byte[0]
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // tag_low[63:0], tag_high[127:64]
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	logic [63:0] key_q [4];
	logic        fj_valid, fj_ready, bj_valid, bj_ready;
	job_t        fj, bj;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	p1305_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.data_byte(s_tdata), .has_byte(s_tuser), .last(s_tlast),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	p1305_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
	);

	p1305_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.r_key({key_q[REG_R_HIGH], key_q[REG_R_LOW]}),
		.s_key({key_q[REG_S_HIGH], key_q[REG_S_LOW]}),
		.tag_valid(m_tvalid), .tag_ready(m_tready), .tag(m_tdata)
	);
endmodule
